>>> design/bankers_safety_check_macros.svh
// Assertion helpers used by the safety check design file.
`ifndef BANKERS_SAFETY_CHECK_MACROS_SVH
`define BANKERS_SAFETY_CHECK_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BSC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/bsc_pkg.sv
package bsc_pkg;

   // Sizing of the tables.
   localparam int PROCESSES   = 5;
   localparam int RESOURCES   = 3;
   localparam int COUNT_WIDTH = 8;

   localparam int PROC_AW    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int RES_AW     = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
   localparam int DONE_WIDTH = $clog2(PROCESSES + 1);
   // The work vector holds the available units plus every allocation.
   localparam int WORK_WIDTH = COUNT_WIDTH + DONE_WIDTH;

   // Fixed widths of the port fields.
   localparam int CMD_WIDTH      = 3;
   localparam int PROC_FW        = 3;
   localparam int RES_FW         = 2;
   localparam int AMOUNT_WIDTH   = 8;
   localparam int STATUS_WIDTH   = 3;

   typedef logic [COUNT_WIDTH-1:0]                    count_type;
   typedef logic [RESOURCES-1:0][COUNT_WIDTH-1:0]     vec_type;
   typedef logic [RESOURCES-1:0][WORK_WIDTH-1:0]      work_type;
   typedef logic [PROC_AW-1:0]                        proc_addr_type;

   // One memory row holds both tables for one process.
   typedef struct packed {
      vec_type max_claim;
      vec_type alloc;
   } row_type;

   // Per-entry write enables for one row.
   typedef struct packed {
      logic [RESOURCES-1:0] max_claim;
      logic [RESOURCES-1:0] alloc;
   } wmask_type;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_WRITE_ALLOC = 3'd0,
      CMD_WRITE_MAX   = 3'd1,
      CMD_WRITE_AVAIL = 3'd2,
      CMD_STAGE       = 3'd3,
      CMD_CHECK       = 3'd4,
      CMD_SUBMIT      = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STS_WRITTEN          = 3'd0,
      STS_SAFE             = 3'd1,
      STS_UNSAFE           = 3'd2,
      STS_GRANTED          = 3'd3,
      STS_DENIED_UNSAFE    = 3'd4,
      STS_DENIED_TOO_LARGE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUB_TEST,
      ST_CHECK
   } state_type;

endpackage

>>> design/bankers_safety_check.sv
// Channel    Ports                                              Transfer when
// command    start, busy, req_command/process/resource/amount   start high, busy low
// result     rsp_strobe, rsp_status                             rsp_strobe high
//
// Table writes and vector writes give their status in the cycle after the command is taken.
// A safety check reads and tests one memory row per cycle, over up to PROCESSES
// passes. A submit first reads the row of its process and tests the request
// against need and available before the check.
// Reset is synchronous; the tables read as zero until an entry is written.
// The receiver cannot stall: each status is shown for one cycle only.
module bankers_safety_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [bsc_pkg::CMD_WIDTH-1:0]    req_command,
   input  logic [bsc_pkg::PROC_FW-1:0]      req_process,
   input  logic [bsc_pkg::RES_FW-1:0]       req_resource,
   input  logic [bsc_pkg::AMOUNT_WIDTH-1:0] req_amount,
   output logic                           rsp_strobe,
   output logic [bsc_pkg::STATUS_WIDTH-1:0] rsp_status
);
   import bsc_pkg::*;
   `include "bankers_safety_check_macros.svh"

   state_type state_ff, state_in;
   vec_type   avail_ff, avail_in;
   vec_type   staged_ff, staged_in;
   vec_type   orig_alloc_ff, orig_alloc_in;
   work_type  work_ff, work_in;
   logic [PROCESSES-1:0] fin_ff, fin_in;
   logic [DONE_WIDTH-1:0] done_cnt_ff, done_cnt_in;
   logic progress_ff, progress_in;
   proc_addr_type rd_p_ff, rd_p_in;
   proc_addr_type eval_p_ff, eval_p_in;
   logic eval_vld_ff, eval_vld_in;
   proc_addr_type sub_p_ff, sub_p_in;
   logic submit_ff, submit_in;
   logic [PROCESSES-1:0][RESOURCES-1:0] alloc_vld_ff, alloc_vld_in;
   logic [PROCESSES-1:0][RESOURCES-1:0] max_vld_ff, max_vld_in;
   proc_addr_type raddr_q_ff;
   logic rsp_strobe_ff, rsp_strobe_in;
   status_type rsp_status_ff, rsp_status_in;

   logic          accept;
   logic          p_ok, r_ok;
   proc_addr_type p_idx;
   logic [RES_AW-1:0] r_idx;
   count_type     amount;

   logic          ram_we;
   proc_addr_type ram_waddr, ram_raddr;
   wmask_type     ram_wmask;
   row_type       ram_wdata, ram_rdata, row;
   vec_type       need;

   logic fits, done_all, finish_safe, finish_unsafe, progress_after, sub_ok;
   logic [DONE_WIDTH-1:0] done_after;
   work_type work_after;

   bsc_table_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_mask (ram_wmask),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign p_ok       = (int'(req_process) < PROCESSES);
   assign r_ok       = (int'(req_resource) < RESOURCES);
   assign p_idx      = PROC_AW'(req_process);
   assign r_idx      = RES_AW'(req_resource);
   assign amount     = req_amount[COUNT_WIDTH-1:0];
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;

   // Entries never written read as zero; the need saturates at zero.
   always_comb begin
      for (int r = 0; r < RESOURCES; r++) begin
         row.alloc[r] = alloc_vld_ff[raddr_q_ff][r] ? ram_rdata.alloc[r] : '0;
         row.max_claim[r] = max_vld_ff[raddr_q_ff][r] ? ram_rdata.max_claim[r] : '0;
         need[r] = (row.max_claim[r] > row.alloc[r]) ?
                   count_type'(row.max_claim[r] - row.alloc[r]) : '0;
      end
   end

   // Request test and one step of the safety pass on the row just read.
   always_comb begin
      sub_ok = 1'b1;
      fits   = eval_vld_ff && !fin_ff[eval_p_ff];
      for (int r = 0; r < RESOURCES; r++) begin
         if (staged_ff[r] > need[r] || staged_ff[r] > avail_ff[r]) begin
            sub_ok = 1'b0;
         end
         if (WORK_WIDTH'(need[r]) > work_ff[r]) begin
            fits = 1'b0;
         end
         work_after[r] = work_ff[r] + WORK_WIDTH'(row.alloc[r]);
      end
      done_after     = fits ? done_cnt_ff + 1'b1 : done_cnt_ff;
      progress_after = progress_ff || fits;
      done_all       = (int'(done_after) == PROCESSES);
      finish_safe    = eval_vld_ff && done_all;
      finish_unsafe  = eval_vld_ff && !done_all &&
                       (int'(eval_p_ff) == PROCESSES - 1) && !progress_after;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_CHECK) begin
               state_in = ST_CHECK;
            end else if (accept && req_command == CMD_SUBMIT && p_ok) begin
               state_in = ST_SUB_TEST;
            end
         end
         ST_SUB_TEST: begin
            state_in = sub_ok ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            if (finish_safe || finish_unsafe) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls for each state.
   always_comb begin
      avail_in      = avail_ff;
      staged_in     = staged_ff;
      orig_alloc_in = orig_alloc_ff;
      work_in       = work_ff;
      fin_in        = fin_ff;
      done_cnt_in   = done_cnt_ff;
      progress_in   = progress_ff;
      rd_p_in       = rd_p_ff;
      eval_p_in     = eval_p_ff;
      eval_vld_in   = 1'b0;
      sub_p_in      = sub_p_ff;
      submit_in     = submit_ff;
      alloc_vld_in  = alloc_vld_ff;
      max_vld_in    = max_vld_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STS_WRITTEN;
      ram_we        = 1'b0;
      ram_waddr     = p_idx;
      ram_raddr     = p_idx;
      ram_wmask     = '0;
      ram_wdata     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_WRITE_ALLOC: begin
                     rsp_strobe_in = 1'b1;
                     if (p_ok && r_ok) begin
                        ram_we                  = 1'b1;
                        ram_wmask.alloc[r_idx]  = 1'b1;
                        ram_wdata.alloc[r_idx]  = amount;
                        alloc_vld_in[p_idx][r_idx] = 1'b1;
                     end
                  end
                  CMD_WRITE_MAX: begin
                     rsp_strobe_in = 1'b1;
                     if (p_ok && r_ok) begin
                        ram_we                     = 1'b1;
                        ram_wmask.max_claim[r_idx] = 1'b1;
                        ram_wdata.max_claim[r_idx] = amount;
                        max_vld_in[p_idx][r_idx]   = 1'b1;
                     end
                  end
                  CMD_WRITE_AVAIL: begin
                     rsp_strobe_in = 1'b1;
                     if (r_ok) begin
                        avail_in[r_idx] = amount;
                     end
                  end
                  CMD_STAGE: begin
                     rsp_strobe_in = 1'b1;
                     if (r_ok) begin
                        staged_in[r_idx] = amount;
                     end
                  end
                  CMD_CHECK: begin
                     for (int r = 0; r < RESOURCES; r++) begin
                        work_in[r] = WORK_WIDTH'(avail_ff[r]);
                     end
                     fin_in      = '0;
                     done_cnt_in = '0;
                     progress_in = 1'b0;
                     rd_p_in     = '0;
                     submit_in   = 1'b0;
                  end
                  CMD_SUBMIT: begin
                     // The row read issued here is tested in the next cycle.
                     sub_p_in = p_idx;
                     if (!p_ok) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_DENIED_TOO_LARGE;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SUB_TEST: begin
            if (!sub_ok) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STS_DENIED_TOO_LARGE;
            end else begin
               // Apply the request tentatively and start the check.
               orig_alloc_in = row.alloc;
               ram_we        = 1'b1;
               ram_waddr     = sub_p_ff;
               ram_wmask.alloc = '1;
               for (int r = 0; r < RESOURCES; r++) begin
                  ram_wdata.alloc[r] = row.alloc[r] + staged_ff[r];
                  avail_in[r]        = avail_ff[r] - staged_ff[r];
                  work_in[r]         = WORK_WIDTH'(avail_in[r]);
               end
               alloc_vld_in[sub_p_ff] = '1;
               fin_in      = '0;
               done_cnt_in = '0;
               progress_in = 1'b0;
               rd_p_in     = '0;
               submit_in   = 1'b1;
            end
         end
         ST_CHECK: begin
            // Read the next row while the previous one is tested.
            ram_raddr   = rd_p_ff;
            rd_p_in     = (int'(rd_p_ff) == PROCESSES - 1) ? '0 : rd_p_ff + 1'b1;
            eval_p_in   = rd_p_ff;
            eval_vld_in = 1'b1;
            if (fits) begin
               work_in           = work_after;
               fin_in[eval_p_ff] = 1'b1;
            end
            done_cnt_in = done_after;
            progress_in = (int'(eval_p_ff) == PROCESSES - 1) ? 1'b0 : progress_after;
            if (finish_safe) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = submit_ff ? STS_GRANTED : STS_SAFE;
            end else if (finish_unsafe) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = submit_ff ? STS_DENIED_UNSAFE : STS_UNSAFE;
               if (submit_ff) begin
                  // Roll the tentative request back.
                  ram_we          = 1'b1;
                  ram_waddr       = sub_p_ff;
                  ram_wmask.alloc = '1;
                  ram_wdata.alloc = orig_alloc_ff;
                  for (int r = 0; r < RESOURCES; r++) begin
                     avail_in[r] = avail_ff[r] + staged_ff[r];
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         avail_ff      <= '0;
         staged_ff     <= '0;
         alloc_vld_ff  <= '0;
         max_vld_ff    <= '0;
         eval_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         fin_ff        <= '0;
         done_cnt_ff   <= '0;
         progress_ff   <= 1'b0;
         submit_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         avail_ff      <= avail_in;
         staged_ff     <= staged_in;
         alloc_vld_ff  <= alloc_vld_in;
         max_vld_ff    <= max_vld_in;
         eval_vld_ff   <= eval_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         fin_ff        <= fin_in;
         done_cnt_ff   <= done_cnt_in;
         progress_ff   <= progress_in;
         submit_ff     <= submit_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      orig_alloc_ff <= orig_alloc_in;
      work_ff       <= work_in;
      rd_p_ff       <= rd_p_in;
      eval_p_ff     <= eval_p_in;
      sub_p_ff      <= sub_p_in;
      raddr_q_ff    <= ram_raddr;
      rsp_status_ff <= rsp_status_in;
   end

   `BSC_ASSERT_NEXT(a_write_responds, accept && (req_command == CMD_WRITE_ALLOC), rsp_strobe, "table write gave no status")
   `BSC_ASSERT_SAME(a_quiet_in_check, state_ff == ST_CHECK, !rsp_strobe, "status shown during a check")
   `BSC_ASSERT_SAME(a_done_bound, state_ff == ST_CHECK, int'(done_cnt_ff) <= PROCESSES, "finished count overflow")

endmodule

>>> design/bsc_table_ram.sv
module bsc_table_ram (
   input  logic                   clock,
   input  logic                   wr_en,
   input  bsc_pkg::proc_addr_type wr_addr,
   input  bsc_pkg::wmask_type     wr_mask,
   input  bsc_pkg::row_type       wr_data,
   input  bsc_pkg::proc_addr_type rd_addr,
   output bsc_pkg::row_type       rd_data
);
   import bsc_pkg::*;

   row_type mem_ram [PROCESSES];
   row_type rd_data_ff;

   // Entry-masked write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int r = 0; r < RESOURCES; r++) begin
            if (wr_mask.alloc[r]) begin
               mem_ram[wr_addr].alloc[r] <= wr_data.alloc[r];
            end
            if (wr_mask.max_claim[r]) begin
               mem_ram[wr_addr].max_claim[r] <= wr_data.max_claim[r];
            end
         end
      end
      rd_data_ff <= mem_ram[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/bankers_safety_check_test.sv
module bankers_safety_check_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bsc_pkg::*;

   localparam int NPROC = PROCESSES;
   localparam int NRES = RESOURCES;
   localparam int RANDOM_ITEMS = 1500;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [CMD_WIDTH-1:0] req_command;
   logic [PROC_FW-1:0] req_process;
   logic [RES_FW-1:0] req_resource;
   logic [AMOUNT_WIDTH-1:0] req_amount;
   logic rsp_strobe;
   logic [STATUS_WIDTH-1:0] rsp_status;

   bankers_safety_check uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_process(req_process),
      .req_resource(req_resource), .req_amount(req_amount),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status)
   );

   // Shadow copy of the guard's tables.
   logic [7:0] alloc_shadow [NPROC][NRES];
   logic [7:0] claim_shadow [NPROC][NRES];
   logic [7:0] avail_shadow [NRES];
   logic [7:0] staged_shadow [NRES];

   status_type pending_status [$];
   int mismatches = 0;
   int accepted_status = 0;
   int grants = 0;
   int denials = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] need_units(int p, int r);
      return (claim_shadow[p][r] > alloc_shadow[p][r]) ?
         claim_shadow[p][r] - alloc_shadow[p][r] : 8'd0;
   endfunction

   // Repeated passes over the processes with a widened work vector.
   function automatic bit state_is_safe();
      logic [11:0] work [NRES];
      bit finished [NPROC];
      int done;
      bit progress;
      bit fits;
      done = 0;
      for (int r = 0; r < NRES; r++) work[r] = avail_shadow[r];
      for (int p = 0; p < NPROC; p++) finished[p] = 0;
      while (done < NPROC) begin
         progress = 0;
         for (int p = 0; p < NPROC; p++) begin
            if (!finished[p]) begin
               fits = 1;
               for (int r = 0; r < NRES; r++)
                  if (need_units(p, r) > work[r]) fits = 0;
               if (fits) begin
                  for (int r = 0; r < NRES; r++) work[r] += alloc_shadow[p][r];
                  finished[p] = 1;
                  progress = 1;
                  done++;
               end
            end
         end
         if (!progress) return 0;
      end
      return 1;
   endfunction

   // Applies one command to the shadow state and returns the status it earns.
   function automatic status_type apply_command(logic [2:0] cmd, logic [2:0] p,
         logic [1:0] r, logic [7:0] amt);
      bit p_ok;
      bit r_ok;
      bit ok;
      p_ok = p < NPROC;
      r_ok = r < NRES;
      case (cmd)
         CMD_WRITE_ALLOC: if (p_ok && r_ok) alloc_shadow[p][r] = amt;
         CMD_WRITE_MAX: if (p_ok && r_ok) claim_shadow[p][r] = amt;
         CMD_WRITE_AVAIL: if (r_ok) avail_shadow[r] = amt;
         CMD_STAGE: if (r_ok) staged_shadow[r] = amt;
         CMD_CHECK: return state_is_safe() ? STS_SAFE : STS_UNSAFE;
         CMD_SUBMIT: begin
            ok = p_ok;
            if (ok)
               for (int i = 0; i < NRES; i++)
                  if (staged_shadow[i] > need_units(p, i) ||
                      staged_shadow[i] > avail_shadow[i]) ok = 0;
            if (!ok) return STS_DENIED_TOO_LARGE;
            for (int i = 0; i < NRES; i++) begin
               avail_shadow[i] -= staged_shadow[i];
               alloc_shadow[p][i] += staged_shadow[i];
            end
            if (state_is_safe()) return STS_GRANTED;
            for (int i = 0; i < NRES; i++) begin
               avail_shadow[i] += staged_shadow[i];
               alloc_shadow[p][i] -= staged_shadow[i];
            end
            return STS_DENIED_UNSAFE;
         end
         default: ;
      endcase
      return STS_WRITTEN;
   endfunction

   // Drives one command and waits for its transfer; start stays high between
   // commands unless the sender chooses to idle.
   task automatic send_command(logic [2:0] cmd, logic [2:0] p, logic [1:0] r,
         logic [7:0] amt);
      if ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_process <= p;
      req_resource <= r;
      req_amount <= amt;
      do @(posedge clock); while (busy);
      pending_status.push_back(apply_command(cmd, p, r, amt));
      @(negedge clock);
   endtask

   // Result checking and the watchdog on accepted transfers.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_strobe) begin
            accepted_status++;
            if (pending_status.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Status %0d arrived with nothing expected", rsp_status);
            end else begin
               if (pending_status[0] == STS_GRANTED) grants++;
               if (pending_status[0] == STS_DENIED_UNSAFE) denials++;
               if (rsp_status !== pending_status[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Status mismatch: expected %0d, got %0d",
                        pending_status[0], rsp_status);
               end
               void'(pending_status.pop_front());
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d results pending", pending_status.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   typedef struct {
      logic [2:0] cmd;
      logic [2:0] p;
      logic [1:0] r;
      logic [7:0] amt;
      bit typed;
      status_type want;
   } stim_row;

   stim_row directed [] = '{
      '{CMD_CHECK, 3'd0, 2'd0, 8'd0, 1, STS_SAFE},
      '{CMD_SUBMIT, 3'd0, 2'd0, 8'd0, 1, STS_GRANTED},
      '{CMD_SUBMIT, 3'd5, 2'd0, 8'd0, 1, STS_DENIED_TOO_LARGE},
      '{CMD_SUBMIT, 3'd7, 2'd0, 8'd0, 1, STS_DENIED_TOO_LARGE},
      '{3'd6, 3'd7, 2'd3, 8'hff, 1, STS_WRITTEN},
      '{3'd7, 3'd0, 2'd0, 8'h00, 1, STS_WRITTEN},
      '{CMD_WRITE_ALLOC, 3'd7, 2'd3, 8'hff, 1, STS_WRITTEN},
      '{CMD_WRITE_MAX, 3'd2, 2'd3, 8'hff, 1, STS_WRITTEN},
      '{CMD_WRITE_AVAIL, 3'd0, 2'd3, 8'hff, 1, STS_WRITTEN},
      '{CMD_WRITE_MAX, 3'd4, 2'd2, 8'hff, 1, STS_WRITTEN},
      '{CMD_CHECK, 3'd0, 2'd0, 8'd0, 1, STS_UNSAFE},
      '{CMD_WRITE_AVAIL, 3'd0, 2'd2, 8'hff, 1, STS_WRITTEN},
      '{CMD_CHECK, 3'd0, 2'd0, 8'd0, 1, STS_SAFE},
      '{CMD_STAGE, 3'd0, 2'd2, 8'hff, 1, STS_WRITTEN},
      '{CMD_SUBMIT, 3'd4, 2'd0, 8'd0, 1, STS_GRANTED},
      '{CMD_SUBMIT, 3'd4, 2'd0, 8'd0, 0, STS_WRITTEN},
      '{CMD_WRITE_ALLOC, 3'd4, 2'd2, 8'h00, 0, STS_WRITTEN},
      '{CMD_WRITE_MAX, 3'd0, 2'd0, 8'd9, 0, STS_WRITTEN},
      '{CMD_WRITE_MAX, 3'd1, 2'd0, 8'd9, 0, STS_WRITTEN},
      '{CMD_WRITE_ALLOC, 3'd0, 2'd0, 8'd4, 0, STS_WRITTEN},
      '{CMD_WRITE_ALLOC, 3'd1, 2'd0, 8'd4, 0, STS_WRITTEN},
      '{CMD_WRITE_AVAIL, 3'd0, 2'd0, 8'd2, 0, STS_WRITTEN},
      '{CMD_STAGE, 3'd0, 2'd0, 8'd2, 0, STS_WRITTEN},
      '{CMD_STAGE, 3'd0, 2'd2, 8'd0, 0, STS_WRITTEN},
      '{CMD_SUBMIT, 3'd0, 2'd0, 8'd0, 0, STS_WRITTEN}
   };

   // Random command weighted toward well-formed table loads and requests.
   task automatic send_random(int scale);
      logic [2:0] cmd;
      logic [2:0] p;
      logic [1:0] r;
      logic [7:0] amt;
      int pick;
      pick = $urandom_range(99);
      p = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(NPROC - 1));
      r = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(NRES - 1));
      amt = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(scale));
      if (pick < 15) cmd = CMD_WRITE_ALLOC;
      else if (pick < 32) cmd = CMD_WRITE_MAX;
      else if (pick < 42) cmd = CMD_WRITE_AVAIL;
      else if (pick < 62) cmd = CMD_STAGE;
      else if (pick < 72) cmd = CMD_CHECK;
      else if (pick < 97) cmd = CMD_SUBMIT;
      else cmd = 3'($urandom_range(7, 6));
      if (cmd == CMD_STAGE && $urandom_range(1)) amt = 8'($urandom_range(2));
      send_command(cmd, p, r, amt);
   endtask

   // Stops sending and waits until every expected result has come or the guard limit is reached.
   task automatic wait_drained();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pending_status.size() != 0 && guard < IDLE_LIMIT) begin
         @(negedge clock);
         guard++;
      end
   endtask

   initial begin
      int idle_mix [4] = '{0, 55, 0, 36};
      int loss;
      start = 1'b0;
      req_command = '0;
      req_process = '0;
      req_resource = '0;
      req_amount = '0;
      reset = 1'b1;
      for (int i = 0; i < NPROC; i++)
         for (int j = 0; j < NRES; j++) begin
            alloc_shadow[i][j] = '0;
            claim_shadow[i][j] = '0;
         end
      for (int j = 0; j < NRES; j++) begin
         avail_shadow[j] = '0;
         staged_shadow[j] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: typed expectations are checked against the predictor too.
      foreach (directed[i]) begin
         send_command(directed[i].cmd, directed[i].p, directed[i].r, directed[i].amt);
         if (directed[i].typed && pending_status[$] != directed[i].want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Row %0d: typed status %0d, predicted %0d",
                  i, directed[i].want, pending_status[$]);
         end
      end

      // Hold off until all directed results are in.
      wait_drained();

      // Random phases with different sender idling and value ranges.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_mix[ph];
         for (int n = 0; n < RANDOM_ITEMS / 4; n++)
            send_random((ph % 2) ? 255 : 12);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      loss = pending_status.size();
      if (loss != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", loss);
      end
      $display("Ran %0d statuses: %0d grants, %0d unsafe denials, %0d mismatches.",
         accepted_status, grants, denials, mismatches);
      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/bsc_pkg.sv
design/bsc_table_ram.sv
design/bankers_safety_check.sv
tb/bankers_safety_check_test.sv
